// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared property wrappers for the checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/cma_pkg.sv =====
// ----------------------------------------------------------------------------
// cma_pkg
// Types and constants for the centered moving average unit.
// ----------------------------------------------------------------------------
package cma_pkg;

  localparam int unsigned CFG_BITS = 6;
  localparam logic [CFG_BITS-1:0] CFG_WIDTH_RESET = 6'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_ACCUM,
    ST_DIV,
    ST_OUT
  } state_t;

endpackage

// ===== rtl/centered_moving_average_edges_unit.sv =====
// ----------------------------------------------------------------------------
// centered_moving_average_edges_unit
// Centered moving average over a record of signed samples, odd window,
// radius shrinking symmetrically at both record ends, rounded to nearest.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-----------------------------
//  in      | input     | in_valid / in_stall | in_sample, in_last
//  out     | output    | out_valid/out_stall | out_smoothed, out_last_out
//  cfg     | input     | cfg_wr_en           | cfg_wr_data (window width)
//
//  Each result beat: a setup state, (2r+1) ring reads with one add per cycle,
//  draining the last read and starting the divide, a restoring divide of one
//  quotient bit per cycle (SAMPLE_BITS+clog2(RING_DEPTH)+2 steps), forming the
//  mean, and the output state.
//  in_stall is high from the accepted beat until the sequencer returns to idle.
//  A stalled out beat holds the sequencer in the output state.
//  Reset (rst_n low, synchronous) clears write pointer, counters and width
//  register to 5; ring contents are not cleared and are only read once written.
// ----------------------------------------------------------------------------
module centered_moving_average_edges_unit #(
  parameter int unsigned RING_DEPTH  = 64,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // configuration
  input  logic                                  cfg_wr_en,
  input  logic [cma_pkg::CFG_BITS-1:0]          cfg_wr_data,
  // input beats
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [SAMPLE_BITS-1:0]         in_sample,
  input  logic                                  in_last,
  // result beats
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [SAMPLE_BITS-1:0]         out_smoothed,
  output logic                                  out_last_out
);

  // Largest half width the ring can hold around a center.
  localparam int unsigned HW_CAP = (RING_DEPTH - 1) / 2;
  localparam int unsigned PW     = $clog2(RING_DEPTH);       // ring index
  localparam int unsigned HWW    = $clog2(HW_CAP + 1);       // radius / emitted
  localparam int unsigned BLW    = $clog2(HW_CAP + 2);       // backlog
  localparam int unsigned CW     = HWW + 1;                  // window count 2r+1
  localparam int unsigned DW     = HWW + 2;                  // divisor 2*count
  localparam int unsigned SW     = SAMPLE_BITS + PW;         // running sum
  localparam int unsigned NW     = SW + 2;                   // numerator
  localparam int unsigned DCW    = $clog2(NW + 1);           // divide step count

  // Sample ring; only entries written in this record are ever read.
  logic [SAMPLE_BITS-1:0] ring [RING_DEPTH];
  logic [SAMPLE_BITS-1:0] rd_data_r;

  cma_pkg::state_t state_r, state_nxt;

  logic [cma_pkg::CFG_BITS-1:0] width_r;
  logic [PW-1:0]        wr_ptr_r, wr_ptr_nxt;
  logic [BLW-1:0]       backlog_r, backlog_nxt;
  logic [HWW-1:0]       emit_cnt_r, emit_cnt_nxt;
  logic                 rec_last_r, rec_last_nxt;   // current beat closes the record
  logic                 final_r, final_nxt;         // result being built is the last one

  logic [PW-1:0]        rd_addr_r, rd_addr_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic [CW-1:0]        issue_cnt_r, issue_cnt_nxt;
  logic                 rd_vld_r, rd_vld_nxt;
  logic signed [SW-1:0] sum_r, sum_nxt;

  logic [DW-1:0]        den_r, den_nxt;
  logic [NW-1:0]        mag_r, mag_nxt;
  logic [NW-1:0]        quo_r, quo_nxt;
  logic [DW-1:0]        rem_r, rem_nxt;
  logic                 neg_r, neg_nxt;
  logic [DCW-1:0]       div_cnt_r, div_cnt_nxt;

  logic [SAMPLE_BITS-1:0] out_smoothed_r, out_smoothed_nxt;
  logic                   out_last_r, out_last_nxt;

  // Combinational helpers
  logic                 in_fire;
  logic                 rd_issue;
  logic [HWW-1:0]       hw;
  logic [BLW-1:0]       rad;
  logic [PW:0]          off;
  logic [PW:0]          start_raw;
  logic [PW-1:0]        start_idx;
  logic signed [NW-1:0] num;
  logic [DW:0]          trial;
  logic [NW-1:0]        qmag;
  logic [NW-1:0]        qval;

  assign in_fire      = in_valid && !in_stall;
  assign in_stall     = (state_r != cma_pkg::ST_IDLE);
  assign out_valid    = (state_r == cma_pkg::ST_OUT);
  assign out_smoothed = out_smoothed_r;
  assign out_last_out = out_last_r;

  // Half width: even widths round up to odd, so width>>1 either way; capped.
  always_comb begin
    if (32'(width_r[cma_pkg::CFG_BITS-1:1]) > HW_CAP) begin
      hw = HWW'(HW_CAP);
    end else begin
      hw = HWW'(width_r[cma_pkg::CFG_BITS-1:1]);
    end
  end

  // Radius: min(position, half width), and on flush also min(samples after).
  always_comb begin
    rad = (emit_cnt_r < hw) ? BLW'(emit_cnt_r) : BLW'(hw);
    if (rec_last_r && (backlog_r - BLW'(1)) < rad) begin
      rad = backlog_r - BLW'(1);
    end
  end

  // Window start = write pointer - backlog - radius, modulo ring depth.
  assign off       = (PW+1)'(backlog_r) + (PW+1)'(rad);
  assign start_raw = {1'b0, wr_ptr_r} + (PW+1)'(RING_DEPTH) - off;
  assign start_idx = (start_raw >= (PW+1)'(RING_DEPTH)) ?
                     PW'(start_raw - (PW+1)'(RING_DEPTH)) : PW'(start_raw);

  assign rd_issue = (state_r == cma_pkg::ST_ACCUM) && (issue_cnt_r < count_r);

  // Rounded mean = floor((2*sum + count) / (2*count)).
  assign num   = (sum_r <<< 1) + $signed({1'b0, (NW-1)'(count_r)});
  assign trial = {rem_r, mag_r[NW-1]};
  assign qmag  = quo_r + NW'(neg_r && (rem_r != '0));
  assign qval  = neg_r ? (~qmag + NW'(1)) : qmag;

  always_comb begin
    state_nxt        = state_r;
    wr_ptr_nxt       = wr_ptr_r;
    backlog_nxt      = backlog_r;
    emit_cnt_nxt     = emit_cnt_r;
    rec_last_nxt     = rec_last_r;
    final_nxt        = final_r;
    rd_addr_nxt      = rd_addr_r;
    count_nxt        = count_r;
    issue_cnt_nxt    = issue_cnt_r;
    rd_vld_nxt       = rd_issue;
    sum_nxt          = sum_r;
    den_nxt          = den_r;
    mag_nxt          = mag_r;
    quo_nxt          = quo_r;
    rem_nxt          = rem_r;
    neg_nxt          = neg_r;
    div_cnt_nxt      = div_cnt_r;
    out_smoothed_nxt = out_smoothed_r;
    out_last_nxt     = out_last_r;

    case (state_r)
      cma_pkg::ST_IDLE: begin
        if (in_fire) begin
          wr_ptr_nxt   = (wr_ptr_r == PW'(RING_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
          backlog_nxt  = backlog_r + BLW'(1);
          rec_last_nxt = in_last;
          state_nxt    = cma_pkg::ST_CHECK;
        end
      end

      cma_pkg::ST_CHECK: begin
        // Decide whether another result is due and set up its window.
        if ((rec_last_r && backlog_r != '0) ||
            (!rec_last_r && backlog_r > BLW'(hw))) begin
          rd_addr_nxt   = start_idx;
          count_nxt     = CW'({rad, 1'b1});
          den_nxt       = DW'({rad, 2'b10});
          issue_cnt_nxt = '0;
          sum_nxt       = '0;
          final_nxt     = rec_last_r && (backlog_r == BLW'(1));
          state_nxt     = cma_pkg::ST_ACCUM;
        end else begin
          if (rec_last_r) begin
            emit_cnt_nxt = '0;
            rec_last_nxt = 1'b0;
          end
          state_nxt = cma_pkg::ST_IDLE;
        end
      end

      cma_pkg::ST_ACCUM: begin
        // One ring read issued and one add per cycle; read data comes back the next cycle.
        if (rd_issue) begin
          issue_cnt_nxt = issue_cnt_r + CW'(1);
          rd_addr_nxt   = (rd_addr_r == PW'(RING_DEPTH - 1)) ? '0 : rd_addr_r + PW'(1);
        end
        if (rd_vld_r) begin
          sum_nxt = sum_r + SW'($signed(rd_data_r));
        end
        if (!rd_issue && !rd_vld_r) begin
          neg_nxt     = num[NW-1];
          mag_nxt     = num[NW-1] ? NW'(-num) : NW'(num);
          quo_nxt     = '0;
          rem_nxt     = '0;
          div_cnt_nxt = DCW'(NW);
          state_nxt   = cma_pkg::ST_DIV;
        end
      end

      cma_pkg::ST_DIV: begin
        // Restoring divide, one quotient bit per cycle.
        if (div_cnt_r != '0) begin
          mag_nxt     = mag_r << 1;
          div_cnt_nxt = div_cnt_r - DCW'(1);
          if (trial >= (DW+1)'(den_r)) begin
            rem_nxt = DW'(trial - (DW+1)'(den_r));
            quo_nxt = {quo_r[NW-2:0], 1'b1};
          end else begin
            rem_nxt = DW'(trial);
            quo_nxt = {quo_r[NW-2:0], 1'b0};
          end
        end else begin
          out_smoothed_nxt = qval[SAMPLE_BITS-1:0];
          out_last_nxt     = final_r;
          state_nxt        = cma_pkg::ST_OUT;
        end
      end

      cma_pkg::ST_OUT: begin
        if (!out_stall) begin
          backlog_nxt = backlog_r - BLW'(1);
          if (emit_cnt_r != HWW'(HW_CAP)) begin
            emit_cnt_nxt = emit_cnt_r + HWW'(1);
          end
          state_nxt = cma_pkg::ST_CHECK;
        end
      end

      default: begin
        state_nxt = cma_pkg::ST_IDLE;
      end
    endcase
  end

  // Ring write on accept, registered read during accumulation.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      ring[wr_ptr_r] <= in_sample;
    end
    if (rd_issue) begin
      rd_data_r <= ring[rd_addr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cma_pkg::ST_IDLE;
      width_r     <= cma_pkg::CFG_WIDTH_RESET;
      wr_ptr_r    <= '0;
      backlog_r   <= '0;
      emit_cnt_r  <= '0;
      rec_last_r  <= 1'b0;
      rd_vld_r    <= 1'b0;
      issue_cnt_r <= '0;
      div_cnt_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_wr_en) begin
        width_r <= cfg_wr_data;
      end
      wr_ptr_r    <= wr_ptr_nxt;
      backlog_r   <= backlog_nxt;
      emit_cnt_r  <= emit_cnt_nxt;
      rec_last_r  <= rec_last_nxt;
      rd_vld_r    <= rd_vld_nxt;
      issue_cnt_r <= issue_cnt_nxt;
      div_cnt_r   <= div_cnt_nxt;
    end
  end

  // Datapath registers, no reset needed.
  always_ff @(posedge clk) begin
    final_r        <= final_nxt;
    rd_addr_r      <= rd_addr_nxt;
    count_r        <= count_nxt;
    sum_r          <= sum_nxt;
    den_r          <= den_nxt;
    mag_r          <= mag_nxt;
    quo_r          <= quo_nxt;
    rem_r          <= rem_nxt;
    neg_r          <= neg_nxt;
    out_smoothed_r <= out_smoothed_nxt;
    out_last_r     <= out_last_nxt;
  end

endmodule

// ===== rtl/cma_checker.sv =====
// ----------------------------------------------------------------------------
// cma_checker
// Port-level checks for the centered moving average unit, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cma_checker #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic signed [SAMPLE_BITS-1:0] out_smoothed,
  input logic                          out_last_out
);

  // whole result payload
  logic [SAMPLE_BITS:0] out_beat;
  assign out_beat = {out_smoothed, out_last_out};

  // Stalled result beat holds.
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_beat))

  // No new input while a result waits.
  `ASSERT_SAME(a_busy_on_out, clk, rst_n, out_valid, in_stall)

  // An accepted beat blocks the input next cycle and has no result yet.
  `ASSERT_NEXT(a_accept_busy, clk, rst_n, in_valid && !in_stall, in_stall && !out_valid)

  // A taken result is never followed directly by another.
  `ASSERT_NEXT(a_out_gap, clk, rst_n, out_valid && !out_stall, !out_valid)

endmodule

bind centered_moving_average_edges_unit cma_checker #(
  .SAMPLE_BITS(SAMPLE_BITS)
) u_cma_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_smoothed(out_smoothed),
  .out_last_out(out_last_out)
);
